// ===== rtl/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rmst_pkg: shared definitions for the range-minimum segment tree
// Field widths, command codes, the empty-leaf value, controller states and
// the status bundle passed from the controller to the top level.
// ----------------------------------------------------------------------------
package rmst_pkg;

    // Default tree size; leaf count must be a power of two
    localparam int LEAVES_DEF = 1024;
    localparam int ADDR_W_DEF = $clog2(2 * LEAVES_DEF);

    // Fixed field widths
    localparam int CMD_W = 2;
    localparam int POS_W = 11;
    localparam int VAL_W = 30;

    // Value that marks an empty leaf
    localparam logic [VAL_W-1:0] EMPTY_VALUE = 30'd1000000000;

    // Reset value of the leaves-in-use register
    localparam logic [POS_W-1:0] LEAVES_IN_USE_RST = 11'd1024;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_INIT,    // clearing sweep after reset
        ST_IDLE,    // waiting for a command
        ST_UPD,     // walking from a leaf up to the root
        ST_QRY,     // range walk, two reads per level
        ST_WIPE,    // clearing sweep for a clear command
        ST_DONE     // result waits for the output register
    } t_state;

    // Controller status seen by the top level
    typedef struct packed {
        logic sweeping;
        logic updating;
    } t_rmst_stat;

endpackage

// ===== rtl/rmst_if.sv =====
// ----------------------------------------------------------------------------
// rmst_if: channel interfaces for the range-minimum segment tree
// Command channel, result channel and configuration write channel, each a
// valid/ready handshake with a source and a sink modport.
// ----------------------------------------------------------------------------
interface rmst_cmd_if;
    import rmst_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] new_value;
    logic [POS_W-1:0] range_start;
    logic [POS_W-1:0] range_end;

    modport source (
        output valid, command, position, new_value, range_start, range_end,
        input  ready
    );
    modport sink (
        input  valid, command, position, new_value, range_start, range_end,
        output ready
    );
endinterface

interface rmst_res_if;
    import rmst_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] min_value;
    logic             range_error;

    modport source (
        output valid, min_value, range_error,
        input  ready
    );
    modport sink (
        input  valid, min_value, range_error,
        output ready
    );
endinterface

interface rmst_cfg_if;
    import rmst_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] leaves_in_use;

    modport source (
        output valid, leaves_in_use,
        input  ready
    );
    modport sink (
        input  valid, leaves_in_use,
        output ready
    );
endinterface

// ===== rtl/rmst_mem.sv =====
// ----------------------------------------------------------------------------
// rmst_mem: node storage of the segment tree
// One write port and two read ports, read data registered.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module rmst_mem #(
    parameter int AW = rmst_pkg::ADDR_W_DEF,
    parameter int DW = rmst_pkg::VAL_W
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr_a,
    input  logic [AW-1:0] i_rd_addr_b,
    output logic [DW-1:0] o_rd_data_a,
    output logic [DW-1:0] o_rd_data_b
);

    logic [DW-1:0] mem [2**AW];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        o_rd_data_a <= mem[i_rd_addr_a];
        o_rd_data_b <= mem[i_rd_addr_b];
    end

endmodule

// ===== rtl/rmst_eng.sv =====
// ----------------------------------------------------------------------------
// rmst_eng: command sequencer of the segment tree
// Decodes commands, walks the tree through the node memory (leaf-to-root
// update, two-sided range walk, clearing sweep) and holds the result register.
// ----------------------------------------------------------------------------
module rmst_eng #(
    parameter  int LEAVES = rmst_pkg::LEAVES_DEF,
    localparam int AW     = $clog2(2 * LEAVES)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rmst_cfg_if.sink                   i_cfg,
    rmst_cmd_if.sink                   i_cmd,
    rmst_res_if.source                 o_res,
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output logic [rmst_pkg::VAL_W-1:0] o_wr_data,
    output logic [AW-1:0]              o_rd_addr_a,
    output logic [AW-1:0]              o_rd_addr_b,
    input  logic [rmst_pkg::VAL_W-1:0] i_rd_data_a,
    input  logic [rmst_pkg::VAL_W-1:0] i_rd_data_b,
    output rmst_pkg::t_rmst_stat       o_stat
);
    import rmst_pkg::*;

    localparam int AW1 = AW + 1;
    localparam int CW  = (AW > POS_W) ? AW : POS_W;

    // Control state
    t_state           r_state, n_state;
    logic [AW-1:0]    r_cnt, n_cnt;
    logic             r_en_a, n_en_a;
    logic             r_en_b, n_en_b;
    logic             r_out_valid;
    logic [POS_W-1:0] r_leaves;

    // Datapath registers
    logic [AW-1:0]    r_k, n_k;
    logic [VAL_W-1:0] r_cur, n_cur;
    logic [VAL_W-1:0] r_res, n_res;
    logic             r_err, n_err;
    logic [AW1-1:0]   r_a, n_a;
    logic [AW1-1:0]   r_b, n_b;
    logic [VAL_W-1:0] r_out_min;
    logic             r_out_err;

    // Decode helpers
    logic             cmd_acc;
    logic             out_load;
    logic [CW-1:0]    used;
    logic [CW-1:0]    pos_c, rs_c, re_c;
    logic             pos_bad, qry_bad;
    logic [VAL_W-1:0] new_val;
    logic [AW-1:0]    leaf;
    logic [AW-1:0]    parent;
    logic [VAL_W-1:0] upd_min;
    logic [VAL_W-1:0] fold_a, fold_ab;
    logic [AW1-1:0]   qa, qb, wb;

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || o_res.ready);

    assign o_res.valid       = r_out_valid;
    assign o_res.min_value   = r_out_min;
    assign o_res.range_error = r_out_err;

    assign o_stat.sweeping = (r_state == ST_INIT) || (r_state == ST_WIPE);
    assign o_stat.updating = (r_state == ST_UPD);

    // Range checks against the leaves in use
    always_comb begin
        used    = (CW'(r_leaves) > CW'(LEAVES)) ? CW'(LEAVES) : CW'(r_leaves);
        pos_c   = CW'(i_cmd.position);
        rs_c    = CW'(i_cmd.range_start);
        re_c    = CW'(i_cmd.range_end);
        pos_bad = (pos_c == '0) || (pos_c > used);
        qry_bad = (rs_c == '0) || (re_c > used) || (rs_c > re_c);
        new_val = (i_cmd.new_value > EMPTY_VALUE) ? EMPTY_VALUE : i_cmd.new_value;
        leaf    = AW'(LEAVES) + AW'(pos_c) - AW'(1);
        qa      = AW1'(LEAVES) + AW1'(rs_c) - AW1'(1);
        qb      = AW1'(LEAVES) + AW1'(re_c);
        wb      = AW1'(LEAVES) + AW1'(used);
    end

    // Tree walk arithmetic
    always_comb begin
        parent  = r_k >> 1;
        upd_min = (i_rd_data_a < r_cur) ? i_rd_data_a : r_cur;
        fold_a  = (r_en_a && (i_rd_data_a < r_res)) ? i_rd_data_a : r_res;
        fold_ab = (r_en_b && (i_rd_data_b < fold_a)) ? i_rd_data_b : fold_a;
    end

    // Next state and memory port control
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_en_a      = r_en_a;
        n_en_b      = r_en_b;
        n_k         = r_k;
        n_cur       = r_cur;
        n_res       = r_res;
        n_err       = r_err;
        n_a         = r_a;
        n_b         = r_b;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_cnt;
        o_wr_data   = EMPTY_VALUE;
        o_rd_addr_a = {r_k[AW-1:1], ~r_k[0]};
        o_rd_addr_b = {r_k[AW-1:1], ~r_k[0]};

        case (r_state)
            ST_INIT, ST_WIPE: begin
                o_wr_en = 1'b1;
                n_cnt   = r_cnt + AW'(1);
                if (&r_cnt) begin
                    n_res   = EMPTY_VALUE;
                    n_err   = 1'b0;
                    n_state = (r_state == ST_WIPE) ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd_acc) begin
                    n_res   = EMPTY_VALUE;
                    n_err   = 1'b0;
                    n_state = ST_DONE;
                    case (i_cmd.command)
                        CMD_WRITE: begin
                            if (pos_bad) begin
                                n_err = 1'b1;
                            end else begin
                                // store the leaf, fetch its sibling
                                o_wr_en     = 1'b1;
                                o_wr_addr   = leaf;
                                o_wr_data   = new_val;
                                o_rd_addr_a = {leaf[AW-1:1], ~leaf[0]};
                                o_rd_addr_b = {leaf[AW-1:1], ~leaf[0]};
                                n_k         = leaf;
                                n_cur       = new_val;
                                n_state     = ST_UPD;
                            end
                        end
                        CMD_QUERY: begin
                            if (qry_bad) begin
                                n_err = 1'b1;
                            end else begin
                                n_a     = qa;
                                n_b     = qb;
                                n_en_a  = 1'b0;
                                n_en_b  = 1'b0;
                                n_state = ST_QRY;
                            end
                        end
                        CMD_CLEAR: begin
                            n_cnt   = '0;
                            n_state = ST_WIPE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_UPD: begin
                // parent = min(current, sibling); fetch parent's sibling
                o_wr_en     = 1'b1;
                o_wr_addr   = parent;
                o_wr_data   = upd_min;
                o_rd_addr_a = {parent[AW-1:1], ~parent[0]};
                o_rd_addr_b = {parent[AW-1:1], ~parent[0]};
                n_k         = parent;
                n_cur       = upd_min;
                if (parent == AW'(1)) begin
                    // root written: report minimum over all leaves in use
                    n_a     = AW1'(LEAVES);
                    n_b     = wb;
                    n_en_a  = 1'b0;
                    n_en_b  = 1'b0;
                    n_res   = EMPTY_VALUE;
                    n_state = ST_QRY;
                end
            end
            ST_QRY: begin
                // fold last cycle's reads, issue this level's reads
                n_res = fold_ab;
                if (r_a < r_b) begin
                    o_rd_addr_a = r_a[AW-1:0];
                    o_rd_addr_b = AW'(r_b - AW1'(1));
                    n_en_a      = r_a[0];
                    n_en_b      = r_b[0];
                    n_a         = (r_a + AW1'(r_a[0])) >> 1;
                    n_b         = (r_b - AW1'(r_b[0])) >> 1;
                end else begin
                    n_en_a  = 1'b0;
                    n_en_b  = 1'b0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_en_a      <= 1'b0;
            r_en_b      <= 1'b0;
            r_out_valid <= 1'b0;
            r_leaves    <= LEAVES_IN_USE_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_en_a  <= n_en_a;
            r_en_b  <= n_en_b;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_leaves <= i_cfg.leaves_in_use;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_cur <= n_cur;
        r_res <= n_res;
        r_err <= n_err;
        r_a   <= n_a;
        r_b   <= n_b;
        if (out_load) begin
            r_out_min <= r_res;
            r_out_err <= r_err;
        end
    end

endmodule

// ===== rtl/range_min_segment_tree.sv =====
// ----------------------------------------------------------------------------
// range_min_segment_tree: range-minimum segment tree with point update
// Bottom-up tree of minima over LEAVES positions kept in a node memory.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command per transaction: write a leaf, query the
//   minimum over an inclusive range, or clear the tree. o_res returns one
//   result per command: min_value and range_error. i_cfg writes the number
//   of leaves in use; write it only while no command is outstanding.
// Command flow:
//   query: a range walk from accept to result register, one level per
//          cycle over two memory read ports.
//   write: one cycle per level up to the root, then a range walk over all
//          leaves in use for the reported minimum.
//   clear: a sweep over the node memory, one memory entry per cycle.
//   Bad indices and unused commands skip the walk; one command at a time.
// Reset: a clearing sweep fills every node with the empty value;
//   i_cmd.ready stays low until it completes, configuration writes are taken.
// Stall: the output register holds a result while o_res.ready is low; the
//   next command is accepted meanwhile and its result waits in the engine.
// ----------------------------------------------------------------------------
module range_min_segment_tree #(
    parameter  int LEAVES = rmst_pkg::LEAVES_DEF,
    localparam int AW     = $clog2(2 * LEAVES)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmst_cfg_if.sink   i_cfg,
    rmst_cmd_if.sink   i_cmd,
    rmst_res_if.source o_res
);
    import rmst_pkg::*;

    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [VAL_W-1:0] mem_wr_data;
    logic [AW-1:0]    mem_rd_addr_a;
    logic [AW-1:0]    mem_rd_addr_b;
    logic [VAL_W-1:0] mem_rd_data_a;
    logic [VAL_W-1:0] mem_rd_data_b;
    t_rmst_stat       eng_stat;

    // Command sequencer
    rmst_eng #(
        .LEAVES (LEAVES)
    ) u_eng (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_cmd       (i_cmd),
        .o_res       (o_res),
        .o_wr_en     (mem_wr_en),
        .o_wr_addr   (mem_wr_addr),
        .o_wr_data   (mem_wr_data),
        .o_rd_addr_a (mem_rd_addr_a),
        .o_rd_addr_b (mem_rd_addr_b),
        .i_rd_data_a (mem_rd_data_a),
        .i_rd_data_b (mem_rd_data_b),
        .o_stat      (eng_stat)
    );

    // Node memory
    rmst_mem #(
        .AW (AW),
        .DW (VAL_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (mem_wr_en),
        .i_wr_addr   (mem_wr_addr),
        .i_wr_data   (mem_wr_data),
        .i_rd_addr_a (mem_rd_addr_a),
        .i_rd_addr_b (mem_rd_addr_b),
        .o_rd_data_a (mem_rd_data_a),
        .o_rd_data_b (mem_rd_data_b)
    );

`ifndef SYNTH
    // No commands right after reset: the clearing sweep runs first
    a_sweep_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_cmd.ready)
        else $error("command accepted before clearing sweep");

    // Sweep writes only the empty value
    a_sweep_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_wr_en && eng_stat.sweeping) |-> (mem_wr_data == EMPTY_VALUE))
        else $error("sweep wrote a non-empty value");

    // Path update never reads the node it writes in the same cycle
    a_upd_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_wr_en && eng_stat.updating) |->
            ((mem_wr_addr != mem_rd_addr_a) && (mem_wr_addr != mem_rd_addr_b)))
        else $error("update read collides with write");

    // An error result always carries the empty value
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.range_error) |-> (o_res.min_value == EMPTY_VALUE))
        else $error("error result with non-empty minimum");
`endif

endmodule

// ===== dv/tb_range_min_segment_tree.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_range_min_segment_tree: self-checking bench for the range-minimum tree
// Drives write, query, clear and unused commands over a range of leaf counts,
// with random gaps on the command side and random stalls on the result side.
// A scoreboard keeps a flat copy of the leaves, predicts each result in order
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_range_min_segment_tree;
    import rmst_pkg::*;

    localparam int LEAVES          = LEAVES_DEF;
    localparam int CLK_PERIOD      = 12;
    localparam int WATCHDOG_LIMIT  = 12000;   // covers a clear or reset sweep
    localparam int TAIL_CYCLES     = 64;
    localparam int PHASE_ITEMS     = 155;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0] min_value;
        logic             range_error;
    } t_rmst_result;

    // ------------------------------------------------------------------------
    // Scoreboard: leaf contents, leaves-in-use register, pending results
    // ------------------------------------------------------------------------
    class t_rmst_scoreboard;
        logic [VAL_W-1:0] leaf_value [LEAVES];   // position p lives at p-1
        logic [POS_W-1:0] leaves_reg;
        t_rmst_result     expected_q [$];
        int               mismatches;

        function new();
            leaves_reg = LEAVES_IN_USE_RST;
            mismatches = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (leaf_value[k]) leaf_value[k] = EMPTY_VALUE;
        endfunction

        function void set_leaves(logic [POS_W-1:0] value);
            leaves_reg = value;
        endfunction

        // register values above the tree size saturate
        function int unsigned active_leaves();
            return (leaves_reg > LEAVES) ? LEAVES : leaves_reg;
        endfunction

        function logic [VAL_W-1:0] span_min(int unsigned lo, int unsigned hi);
            logic [VAL_W-1:0] m;
            m = EMPTY_VALUE;
            for (int unsigned p = lo; p <= hi; p++)
                if (leaf_value[p-1] < m) m = leaf_value[p-1];
            return m;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Accepted command: update the leaves and queue the expected result
        function void note_cmd(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic [VAL_W-1:0] val, logic [POS_W-1:0] rs,
                               logic [POS_W-1:0] re);
            t_rmst_result exp_res;
            int unsigned  used;
            used = active_leaves();
            exp_res.min_value   = EMPTY_VALUE;
            exp_res.range_error = 1'b0;
            case (cmd)
                CMD_WRITE: begin
                    if (pos == 0 || pos > used) begin
                        exp_res.range_error = 1'b1;
                    end else begin
                        leaf_value[pos-1] = (val > EMPTY_VALUE) ? EMPTY_VALUE : val;
                        exp_res.min_value = span_min(1, used);
                    end
                end
                CMD_QUERY: begin
                    if (rs == 0 || re > used || rs > re)
                        exp_res.range_error = 1'b1;
                    else
                        exp_res.min_value = span_min(rs, re);
                end
                CMD_CLEAR: wipe();
                default: ;   // unused code: no state change
            endcase
            expected_q.insert(expected_q.size(), exp_res);
        endfunction

        // Returned result: compare with the oldest expectation
        function void check_result(logic [VAL_W-1:0] min_value, logic range_error);
            t_rmst_result exp_res;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected: min_value %0d error %0b",
                         $time, min_value, range_error);
                return;
            end
            exp_res = expected_q.pop_front();
            if (exp_res.min_value !== min_value) begin
                mismatches++;
                $display("%0t: min_value mismatch: expected %0d actual %0d",
                         $time, exp_res.min_value, min_value);
            end
            if (exp_res.range_error !== range_error) begin
                mismatches++;
                $display("%0t: range_error mismatch: expected %0b actual %0b",
                         $time, exp_res.range_error, range_error);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rmst_cfg_if cfg_ch ();
    rmst_cmd_if cmd_ch ();
    rmst_res_if res_ch ();

    range_min_segment_tree dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    t_rmst_scoreboard sb = new();
    bit               calm_mode = 1'b0;   // no gaps or stalls while set
    int               idle_cycles = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        if (calm_mode) return 0;
        return $urandom_range(0, 8);
    endfunction

    // ------------------------------------------------------------------------
    // Driver tasks; all start and end at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                            logic [VAL_W-1:0] val, logic [POS_W-1:0] rs,
                            logic [POS_W-1:0] re);
        int gap;
        gap = draw_gap();
        repeat (gap) @(negedge i_clk);
        cmd_ch.valid       = 1'b1;
        cmd_ch.command     = cmd;
        cmd_ch.position    = pos;
        cmd_ch.new_value   = val;
        cmd_ch.range_start = rs;
        cmd_ch.range_end   = re;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
        sb.note_cmd(cmd, pos, val, rs, re);
        @(negedge i_clk);
        cmd_ch.valid = 1'b0;
    endtask

    task automatic write_cfg(logic [POS_W-1:0] value);
        cfg_ch.valid         = 1'b1;
        cfg_ch.leaves_in_use = value;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        sb.set_leaves(value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return EMPTY_VALUE;
            2:       return VAL_W'($urandom);
            3:       return EMPTY_VALUE + VAL_W'($urandom_range(1, 1000));
            4:       return VAL_W'($urandom_range(0, EMPTY_VALUE));
            default: return VAL_W'($urandom_range(0, 1000000));
        endcase
    endfunction

    // One random command: mostly well-formed writes and queries
    task automatic random_item();
        int unsigned      used, pick, lo, hi;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos, rs, re;
        logic [VAL_W-1:0] val;
        if ($urandom_range(0, 49) == 0) calm_mode = !calm_mode;
        used = sb.active_leaves();
        pos  = POS_W'($urandom);
        val  = VAL_W'($urandom);
        rs   = POS_W'($urandom);
        re   = POS_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 1) begin
            cmd = CMD_CLEAR;
        end else if (pick < 3) begin
            cmd = CMD_UNUSED;
        end else if (pick < 48) begin
            cmd = CMD_WRITE;
            val = pick_value();
            if (used > 0 && $urandom_range(0, 9) != 0) begin
                pos = POS_W'($urandom_range(1, used));
            end else begin
                case ($urandom_range(0, 2))
                    0:       pos = '0;
                    1:       pos = POS_W'($urandom_range(used + 1, 2047));
                    default: ;
                endcase
            end
        end else begin
            cmd = CMD_QUERY;
            if (used > 0 && $urandom_range(0, 9) != 0) begin
                lo = $urandom_range(1, used);
                if ($urandom_range(0, 3) == 0) begin
                    hi = $urandom_range(lo, used);
                end else begin
                    hi = lo + $urandom_range(0, 7);
                    if (hi > used) hi = used;
                end
                rs = POS_W'(lo);
                re = POS_W'(hi);
            end else begin
                // malformed range: zero start, end past the leaves, reversed, or random
                case ($urandom_range(0, 3))
                    0: rs = '0;
                    1: begin
                        re = POS_W'($urandom_range(used + 1, 2047));
                        rs = POS_W'($urandom_range(1, re));
                    end
                    2: if (used >= 2) begin
                        hi = $urandom_range(2, used);
                        lo = $urandom_range(1, hi - 1);
                        rs = POS_W'(hi);
                        re = POS_W'(lo);
                    end
                    default: ;
                endcase
            end
        end
        send_cmd(cmd, pos, val, rs, re);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, check every transaction
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        stall        = 0;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                res_ch.ready = 1'b0;
                stall--;
            end else begin
                res_ch.ready = 1'b1;
            end
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                sb.check_result(res_ch.min_value, res_ch.range_error);
                stall = draw_gap();
            end
        end
    end

    // Watchdog: too long without any transaction ends the run
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [POS_W-1:0] phase_leaves [10];
        i_rst_n              = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.command       = CMD_WRITE;
        cmd_ch.position      = '0;
        cmd_ch.new_value     = '0;
        cmd_ch.range_start   = '0;
        cmd_ch.range_end     = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.leaves_in_use = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset leaf count, extremes and malformed indices
        send_cmd(CMD_QUERY, 0, 0, 1, 1024);                 // empty tree
        send_cmd(CMD_WRITE, 1, 0, 0, 0);                    // smallest value
        send_cmd(CMD_WRITE, 1024, EMPTY_VALUE, 0, 0);       // last leaf
        send_cmd(CMD_WRITE, 512, {VAL_W{1'b1}}, 0, 0);      // oversized value
        send_cmd(CMD_WRITE, 0, 5, 0, 0);                    // position zero
        send_cmd(CMD_WRITE, 1025, 5, 0, 0);                 // past the leaves
        send_cmd(CMD_WRITE, 2047, 5, 0, 0);
        send_cmd(CMD_QUERY, 0, 0, 1, 1);
        send_cmd(CMD_QUERY, 0, 0, 1024, 1024);
        send_cmd(CMD_QUERY, 0, 0, 0, 5);                    // start zero
        send_cmd(CMD_QUERY, 0, 0, 5, 1025);                 // end past the leaves
        send_cmd(CMD_QUERY, 0, 0, 10, 9);                   // reversed
        send_cmd(CMD_QUERY, 0, 0, 2047, 2047);
        send_cmd(CMD_UNUSED, 2047, {VAL_W{1'b1}}, 2047, 2047);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0);
        send_cmd(CMD_QUERY, 0, 0, 1, 1024);
        send_cmd(CMD_WRITE, 700, 123, 0, 0);

        // no leaves in use: everything but clear and unused is an error
        wait_idle();
        write_cfg(0);
        send_cmd(CMD_WRITE, 1, 7, 0, 0);
        send_cmd(CMD_QUERY, 0, 0, 1, 1);
        send_cmd(CMD_QUERY, 0, 0, 0, 0);

        // one leaf
        wait_idle();
        write_cfg(1);
        send_cmd(CMD_WRITE, 1, 7, 0, 0);
        send_cmd(CMD_WRITE, 2, 3, 0, 0);
        send_cmd(CMD_QUERY, 0, 0, 1, 1);
        send_cmd(CMD_QUERY, 0, 0, 1, 2);

        // register above the tree size saturates; leaf 700 kept its value
        wait_idle();
        write_cfg(2047);
        send_cmd(CMD_WRITE, 1024, 9, 0, 0);
        send_cmd(CMD_QUERY, 0, 0, 2, 1024);

        // Random phases over several leaf counts
        phase_leaves = '{11'd1024, 11'd2, 11'd2047, 11'd37, 11'd1, 11'd0, 11'd1000,
                         11'd16, 11'd513, POS_W'($urandom_range(3, 1024))};
        foreach (phase_leaves[ph]) begin
            wait_idle();
            write_cfg(phase_leaves[ph]);
            repeat (PHASE_ITEMS) random_item();
        end

        // Drain and close
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
